[rtl/hps_pkg.sv]
// Shared types, constants and state codes for the Hamiltonian path search block.
`default_nettype none
package hps_pkg;

  localparam int ROW_SLOTS        = 16;
  localparam int ROW_W            = 16;
  localparam int VTX_W            = 4;
  localparam int CNT_W            = 5;
  localparam int CAND_W           = 5;
  localparam int POS_W            = 4;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 5;
  localparam int MAX_VERTICES_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VERTEX = 2'd1;

  localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = 5'd16;
  localparam logic [VTX_W-1:0] START_VERTEX_RST = 4'd0;

  typedef struct packed {
    logic [CNT_W-1:0] vertex_count;
    logic [VTX_W-1:0] start_vertex;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_PUSH,
    ST_SCAN,
    ST_POPD,
    ST_OUT_RD,
    ST_OUT_LOAD,
    ST_NOTFOUND
  } state_t;

endpackage
`default_nettype wire

[rtl/hps_ram.sv]
// Generic RAM with one write port and one registered read port.
`default_nettype none
module hps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/hps_ctrl.sv]
// Search sequencer: row loading, backtracking search over the stack RAM, result output.
`default_nettype none
module hps_ctrl #(
  parameter int MAX_VERTICES = hps_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire hps_pkg::cfg_t             cfg,
  input  wire logic                      in_valid,
  output      logic                      in_stall,
  input  wire logic [hps_pkg::VTX_W-1:0] in_row_index,
  input  wire logic [hps_pkg::ROW_W-1:0] in_row_edges,
  input  wire logic                      in_last_row,
  output      logic                      out_valid,
  input  wire logic                      out_stall,
  output      logic                      out_found,
  output      logic [hps_pkg::POS_W-1:0] out_path_position,
  output      logic [hps_pkg::VTX_W-1:0] out_path_vertex,
  output      logic                      out_last
);

  import hps_pkg::*;

  localparam int STACK_DEPTH = (MAX_VERTICES < ROW_SLOTS) ? MAX_VERTICES : ROW_SLOTS;
  localparam int SW          = $clog2(STACK_DEPTH);
  localparam int STK_W       = VTX_W + CAND_W;
  localparam int RA_W        = $clog2(ROW_SLOTS);

  state_t              state_r, state_nxt;
  logic [SW-1:0]       d_r, d_nxt;
  logic [SW-1:0]       k_r, k_nxt;
  logic [VTX_W-1:0]    cur_r, cur_nxt;
  logic [CAND_W-1:0]   cand_r, cand_nxt;
  logic [ROW_W-1:0]    visited_r, visited_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic [POS_W-1:0]    out_pos_r, out_pos_nxt;
  logic [VTX_W-1:0]    out_vtx_r, out_vtx_nxt;
  logic                out_last_r, out_last_nxt;

  logic [CNT_W-1:0]    n_eff;
  logic                in_accept;
  logic                out_free;
  logic                adj_re;
  logic [RA_W-1:0]     adj_raddr;
  logic [ROW_W-1:0]    adj_rdata;
  logic                stk_we, stk_re;
  logic [SW-1:0]       stk_waddr, stk_raddr;
  logic [STK_W-1:0]    stk_wdata, stk_rdata;
  logic [VTX_W-1:0]    stk_vtx;
  logic [CAND_W-1:0]   stk_cand;
  logic [ROW_W-1:0]    avail;
  logic                hit;
  logic [VTX_W-1:0]    hit_idx;

  assign n_eff     = (cfg.vertex_count > CNT_W'(STACK_DEPTH)) ? CNT_W'(STACK_DEPTH)
                                                              : cfg.vertex_count;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign stk_vtx   = stk_rdata[STK_W-1:CAND_W];
  assign stk_cand  = stk_rdata[CAND_W-1:0];

  assign avail = adj_rdata & ~visited_r & ({ROW_W{1'b1}} << cand_r)
               & ~({ROW_W{1'b1}} << n_eff);

  always_comb begin
    hit     = |avail;
    hit_idx = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (avail[b]) begin
        hit_idx = VTX_W'(b);
      end
    end
  end

  hps_ram #(
    .WIDTH(ROW_W),
    .DEPTH(ROW_SLOTS)
  ) u_adj_ram (
    .clk  (clk),
    .we   (in_accept),
    .waddr(in_row_index),
    .wdata(in_row_edges),
    .re   (adj_re),
    .raddr(adj_raddr),
    .rdata(adj_rdata)
  );

  hps_ram #(
    .WIDTH(STK_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .re   (stk_re),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    d_r         <= d_nxt;
    k_r         <= k_nxt;
    cur_r       <= cur_nxt;
    cand_r      <= cand_nxt;
    visited_r   <= visited_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
    out_vtx_r   <= out_vtx_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    d_nxt         = d_r;
    k_nxt         = k_r;
    cur_nxt       = cur_r;
    cand_nxt      = cand_r;
    visited_nxt   = visited_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    out_vtx_nxt   = out_vtx_r;
    out_last_nxt  = out_last_r;
    adj_re        = 1'b0;
    adj_raddr     = cur_r;
    stk_we        = 1'b0;
    stk_waddr     = d_r;
    stk_wdata     = {cur_r, CAND_W'(hit_idx) + CAND_W'(1)};
    stk_re        = 1'b0;
    stk_raddr     = k_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && in_last_row) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        visited_nxt = '0;
        d_nxt       = '0;
        cur_nxt     = cfg.start_vertex;
        if (n_eff == '0 || {1'b0, cfg.start_vertex} >= n_eff) begin
          state_nxt = ST_NOTFOUND;
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (CNT_W'(d_r) + CNT_W'(1) == n_eff) begin
          stk_we    = 1'b1;
          stk_wdata = {cur_r, CAND_W'(0)};
          k_nxt     = '0;
          state_nxt = ST_OUT_RD;
        end else begin
          visited_nxt = visited_r | (ROW_W'(1) << cur_r);
          cand_nxt    = '0;
          adj_re      = 1'b1;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          stk_we    = 1'b1;
          d_nxt     = d_r + SW'(1);
          cur_nxt   = hit_idx;
          state_nxt = ST_PUSH;
        end else begin
          visited_nxt = visited_r & ~(ROW_W'(1) << cur_r);
          if (d_r == '0) begin
            state_nxt = ST_NOTFOUND;
          end else begin
            stk_re    = 1'b1;
            stk_raddr = d_r - SW'(1);
            d_nxt     = d_r - SW'(1);
            state_nxt = ST_POPD;
          end
        end
      end
      ST_POPD: begin
        cur_nxt   = stk_vtx;
        cand_nxt  = stk_cand;
        adj_re    = 1'b1;
        adj_raddr = stk_vtx;
        state_nxt = ST_SCAN;
      end
      ST_OUT_RD: begin
        stk_re    = 1'b1;
        state_nxt = ST_OUT_LOAD;
      end
      ST_OUT_LOAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_pos_nxt   = POS_W'(k_r);
          out_vtx_nxt   = stk_vtx;
          out_last_nxt  = (CNT_W'(k_r) + CNT_W'(1) == n_eff);
          if (CNT_W'(k_r) + CNT_W'(1) == n_eff) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + SW'(1);
            state_nxt = ST_OUT_RD;
          end
        end
      end
      ST_NOTFOUND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_pos_nxt   = '0;
          out_vtx_nxt   = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_path_position = out_pos_r;
  assign out_path_vertex   = out_vtx_r;
  assign out_last          = out_last_r;

  a_push_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH) |-> !visited_r[cur_r])
    else $error("pushed vertex already visited");

  a_scan_visited_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ($countones(visited_r) == (CNT_W'(d_r) + CNT_W'(1))))
    else $error("visited mask out of step with path depth");

  a_scan_cur_visited: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> visited_r[cur_r])
    else $error("current vertex not marked visited");

  a_notfound_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> out_last_r)
    else $error("not-found beat without last");

endmodule
`default_nettype wire

[rtl/hamiltonian_path_search_top.sv]
// Top level of the Hamiltonian path search: configuration registers and search sequencer.
//
// Usage:
//   Configure vertex_count (index 0) and start_vertex (index 1) on the cfg_ channel
//   while the block is idle; cfg_ready is always high.
//   Send adjacency rows on the in_ channel, one beat per cycle. Each beat writes row
//   in_row_index; a beat with in_last_row set also starts the search.
//   During the search and while its results drain, in_stall stays high.
//   The search is a depth-first backtracking walk driven by the stack RAM: each
//   push passes PUSH and SCAN and each backtrack POPD, so its length depends on the graph.
//   On success one beat per path vertex comes out on the out_ channel in path order,
//   each read from the stack RAM, then put in the output register; last is set on the
//   final one. With no path a single beat with found=0 and last=1 comes out.
//   The output register holds its beat while out_stall is high; the sequencer waits.
//   Reset (rst_n low, synchronous) returns the sequencer to idle, drops any pending
//   output beat and restores vertex_count to 16 and start_vertex to 0.
`default_nettype none
module hamiltonian_path_search_top #(
  parameter int MAX_VERTICES = hps_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [hps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic [hps_pkg::VTX_W-1:0]      in_row_index,
  input  wire logic [hps_pkg::ROW_W-1:0]      in_row_edges,
  input  wire logic                           in_last_row,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic                           out_found,
  output      logic [hps_pkg::POS_W-1:0]      out_path_position,
  output      logic [hps_pkg::VTX_W-1:0]      out_path_vertex,
  output      logic                           out_last
);

  import hps_pkg::*;

  logic [CNT_W-1:0] vertex_count_r, vertex_count_nxt;
  logic [VTX_W-1:0] start_vertex_r, start_vertex_nxt;
  cfg_t             cfg;

  assign cfg_ready = 1'b1;

  always_comb begin
    vertex_count_nxt = vertex_count_r;
    start_vertex_nxt = start_vertex_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_VERTEX_COUNT: vertex_count_nxt = cfg_wdata[CNT_W-1:0];
        CFG_START_VERTEX: start_vertex_nxt = cfg_wdata[VTX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= VERTEX_COUNT_RST;
      start_vertex_r <= START_VERTEX_RST;
    end else begin
      vertex_count_r <= vertex_count_nxt;
      start_vertex_r <= start_vertex_nxt;
    end
  end

  assign cfg.vertex_count = vertex_count_r;
  assign cfg.start_vertex = start_vertex_r;

  hps_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_row_index     (in_row_index),
    .in_row_edges     (in_row_edges),
    .in_last_row      (in_last_row),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_path_position(out_path_position),
    .out_path_vertex  (out_path_vertex),
    .out_last         (out_last)
  );

endmodule
`default_nettype wire

[test/tb.sv]
// Self-checking testbench for hamiltonian_path_search_top: random graphs, stalls, register sweeps.
module tb;
  import hps_pkg::*;

  localparam int STEP_BUDGET    = 1000;
  localparam int WATCHDOG_LIMIT = 50000;
  localparam int SETTLE_CYCLES  = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_3 = 2'd3;

  typedef logic [ROW_SLOTS-1:0][ROW_W-1:0] adj_t;
  typedef logic [ROW_SLOTS-1:0][VTX_W-1:0] trail_t;

  typedef struct packed {
    logic [VTX_W-1:0] idx;
    logic [ROW_W-1:0] edges;
    logic             last;
  } row_beat_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
    logic [VTX_W-1:0] vtx;
    logic             last;
  } path_beat_t;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [VTX_W-1:0]      in_row_index = '0;
  logic [ROW_W-1:0]      in_row_edges = '0;
  logic                  in_last_row  = 1'b0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic                  out_found;
  logic [POS_W-1:0]      out_path_position;
  logic [VTX_W-1:0]      out_path_vertex;
  logic                  out_last;

  row_beat_t  row_q[$];
  path_beat_t expected_path_beats[$];
  adj_t       plan_adj;
  adj_t       seen_adj;
  logic [CNT_W-1:0] seen_count = VERTEX_COUNT_RST;
  logic [VTX_W-1:0] seen_start = START_VERTEX_RST;

  int rows_planned = 0;
  int rows_done    = 0;
  int mismatches   = 0;
  int idle_pct     = 0;
  int gap_left     = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;
  bit quiet        = 1'b0;

  row_beat_t  took_beat;
  row_beat_t  next_beat;
  path_beat_t want_beat;

  hamiltonian_path_search_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_row_index      (in_row_index),
    .in_row_edges      (in_row_edges),
    .in_last_row       (in_last_row),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_path_position (out_path_position),
    .out_path_vertex   (out_path_vertex),
    .out_last          (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int live_count(input logic [CNT_W-1:0] cnt);
    return (cnt > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(cnt);
  endfunction

  // Depth-first walk, lowest candidate first; steps counts pushes and pops.
  function automatic bit hunt_path(input adj_t adj, input int n, input int start,
                                   output trail_t trail, output int steps);
    logic [ROW_SLOTS-1:0] seen;
    int cand [ROW_SLOTS];
    int d;
    int i;
    bit pushed;
    trail  = '0;
    steps  = 0;
    seen   = '0;
    d      = 0;
    pushed = 1'b1;
    if (n == 0 || start >= n) return 1'b0;
    trail[0] = start[VTX_W-1:0];
    while (steps <= STEP_BUDGET) begin
      if (pushed) begin
        if (d + 1 == n) return 1'b1;
        seen[trail[d]] = 1'b1;
        cand[d] = 0;
      end
      i = cand[d];
      while (i < n && !(adj[trail[d]][i] && !seen[i])) i++;
      steps++;
      if (i < n) begin
        cand[d] = i + 1;
        d++;
        trail[d] = i[VTX_W-1:0];
        pushed = 1'b1;
      end else begin
        seen[trail[d]] = 1'b0;
        if (d == 0) return 1'b0;
        d--;
        pushed = 1'b0;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [ROW_W-1:0] rand_edges(input int density);
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    logic [ROW_W-1:0] c;
    a = $urandom;
    b = $urandom;
    c = $urandom;
    case (density)
      0: return a & b & c;
      1: return a & b;
      2: return a;
      3: return a | b;
      4: return a | b | c;
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  task automatic absorb_row(input row_beat_t b);
    trail_t     trail;
    int         steps;
    int         n;
    path_beat_t pb;
    seen_adj[b.idx] = b.edges;
    if (b.last) begin
      n = live_count(seen_count);
      if (!hunt_path(seen_adj, n, int'(seen_start), trail, steps)) begin
        pb.found = 1'b0;
        pb.pos   = '0;
        pb.vtx   = '0;
        pb.last  = 1'b1;
        expected_path_beats = {expected_path_beats, pb};
      end else begin
        for (int k = 0; k < n; k++) begin
          pb.found = 1'b1;
          pb.pos   = k[POS_W-1:0];
          pb.vtx   = trail[k];
          pb.last  = (k == n - 1);
          expected_path_beats = {expected_path_beats, pb};
        end
      end
    end
  endtask

  task automatic queue_row(input int idx, input logic [ROW_W-1:0] edges, input bit last);
    row_beat_t b;
    b.idx   = idx[VTX_W-1:0];
    b.edges = edges;
    b.last  = last;
    row_q = {row_q, b};
    plan_adj[idx] = edges;
    rows_planned++;
  endtask

  // Queue one graph load ending in a search; redraw graphs whose search runs too long.
  task automatic plan_search(input int n, input int start);
    adj_t   trial;
    trail_t trail;
    int     steps;
    int     rows[$];
    int     order [ROW_SLOTS];
    int     span;
    int     j;
    int     t;
    int     tmp;
    int     density;
    bit     ok;
    bit     full;
    ok   = 1'b0;
    span = (n == 0) ? 1 : n;
    for (int attempt = 0; attempt < 8 && !ok; attempt++) begin
      trial = plan_adj;
      rows.delete();
      full = ($urandom_range(0, 4) != 0);
      if (!full) begin
        repeat ($urandom_range(1, 3)) rows = {rows, int'($urandom_range(0, ROW_SLOTS - 1))};
      end else begin
        for (j = 0; j < span; j++) order[j] = j;
        for (j = span - 1; j > 0; j--) begin
          t        = $urandom_range(0, j);
          tmp      = order[j];
          order[j] = order[t];
          order[t] = tmp;
        end
        for (j = 0; j < span; j++) rows = {rows, order[j]};
        repeat ($urandom_range(0, 2)) rows = {rows, int'($urandom_range(0, ROW_SLOTS - 1))};
      end
      density = $urandom_range(0, 5);
      foreach (rows[r]) trial[rows[r]] = rand_edges(density);
      if (full && start < n && density >= 1 && $urandom_range(0, 1)) begin
        for (j = 0; j < n; j++) begin
          if (order[j] == start) begin
            order[j] = order[0];
            order[0] = start;
          end
        end
        for (j = 0; j + 1 < n; j++) trial[order[j]][order[j+1]] = 1'b1;
      end
      void'(hunt_path(trial, n, start, trail, steps));
      ok = (steps <= STEP_BUDGET);
    end
    if (!ok) begin
      rows.delete();
      trial = plan_adj;
      for (j = 0; j < span; j++) begin
        rows = {rows, j};
        trial[j] = '1;
      end
    end
    foreach (rows[r]) queue_row(rows[r], trial[rows[r]], r == rows.size() - 1);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_VERTEX_COUNT: seen_count = val[CNT_W-1:0];
      CFG_START_VERTEX: seen_start = val[VTX_W-1:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    while (rows_done != rows_planned || expected_path_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        took_beat.idx   = in_row_index;
        took_beat.edges = in_row_edges;
        took_beat.last  = in_last_row;
        absorb_row(took_beat);
        rows_done++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (row_q.size() > 0) begin
          next_beat = row_q.pop_front();
          in_valid     <= 1'b1;
          in_row_index <= next_beat.idx;
          in_row_edges <= next_beat.edges;
          in_last_row  <= next_beat.last;
          if (!quiet && $urandom_range(0, 99) < idle_pct) gap_left = $urandom_range(1, 13);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_path_beats.size() == 0) begin
          report_mismatch($sformatf("beat with nothing pending: found %0b vertex %0d",
                                    out_found, out_path_vertex));
        end else begin
          want_beat = expected_path_beats.pop_front();
          if (out_found !== want_beat.found)
            report_mismatch($sformatf("found %0b, want %0b", out_found, want_beat.found));
          if (out_path_position !== want_beat.pos)
            report_mismatch($sformatf("path_position %0d, want %0d",
                                      out_path_position, want_beat.pos));
          if (out_path_vertex !== want_beat.vtx)
            report_mismatch($sformatf("path_vertex %0d, want %0d",
                                      out_path_vertex, want_beat.vtx));
          if (out_last !== want_beat.last)
            report_mismatch($sformatf("last %0b, want %0b", out_last, want_beat.last));
        end
      end
      if (hold_left == 0 && !quiet && $urandom_range(0, 99) < idle_pct)
        hold_left = $urandom_range(1, 13);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("** hamiltonian_path_search_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    int cnt;
    int start;
    int n;
    int target;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    idle_pct = 20;

    for (int i = 0; i < ROW_SLOTS; i++)
      queue_row(i, (i == ROW_SLOTS - 1) ? 16'h8000 : ROW_W'(1) << (i + 1), i == ROW_SLOTS - 1);
    queue_row(7, '0, 1'b1);
    queue_row(7, '1, 1'b1);
    settle();

    write_reg(CFG_NO_REG_2, 5'd31);
    write_reg(CFG_NO_REG_3, 5'd0);
    write_reg(CFG_VERTEX_COUNT, 5'd0);
    cfg_valid <= 1'b0;
    queue_row(0, '1, 1'b1);
    settle();

    write_reg(CFG_VERTEX_COUNT, 5'd31);
    write_reg(CFG_START_VERTEX, 5'h1F);
    cfg_valid <= 1'b0;
    queue_row(15, 16'h7FFF, 1'b1);
    settle();

    write_reg(CFG_VERTEX_COUNT, 5'd5);
    write_reg(CFG_START_VERTEX, 5'd7);
    cfg_valid <= 1'b0;
    queue_row(2, 16'h0004, 1'b1);
    settle();

    write_reg(CFG_START_VERTEX, 5'd0);
    write_reg(CFG_VERTEX_COUNT, 5'd1);
    cfg_valid <= 1'b0;
    queue_row(9, 16'h5555, 1'b1);
    settle();

    for (int ph = 0; ph < 9; ph++) begin
      case ($urandom_range(0, 9))
        0:       cnt = 1;
        1:       cnt = 2;
        2:       cnt = 16;
        3:       cnt = $urandom_range(17, 31);
        default: cnt = $urandom_range(3, 8);
      endcase
      n = live_count(cnt[CNT_W-1:0]);
      start = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
      quiet = (ph == 8);
      case ($urandom_range(0, 3))
        0:       idle_pct = 0;
        1:       idle_pct = 5;
        2:       idle_pct = 15;
        default: idle_pct = 35;
      endcase
      write_reg(CFG_VERTEX_COUNT, cnt[CFG_DATA_W-1:0]);
      write_reg(CFG_START_VERTEX, {1'($urandom_range(0, 1)), start[VTX_W-1:0]});
      cfg_valid <= 1'b0;
      target = rows_planned + 42;
      while (rows_planned < target) plan_search(n, start);
      settle();
    end

    if (mismatches == 0) begin
      $display("** hamiltonian_path_search_top: PASSED **");
    end else begin
      $display("** hamiltonian_path_search_top: FAILED **");
    end
    $finish;
  end

endmodule

[hamiltonian_path_search_top.f]
rtl/hps_pkg.sv
rtl/hps_ram.sv
rtl/hps_ctrl.sv
rtl/hamiltonian_path_search_top.sv
test/tb.sv
